// ----- rtl/core/jhtd_pkg.sv -----
// ----------------------------------------------------------------------------
// JPEG Huffman table decoder package
// Field widths, segment layout constants and the result and action codes
// shared by the decoder, its checker and its testbench.
// ----------------------------------------------------------------------------
package jhtd_pkg;

  // Code lengths 1 to 16, one count byte each
  localparam int unsigned NumLengths  = 16;
  localparam int unsigned LenIdxW     = 4;
  // Class/id byte plus the count bytes
  localparam int unsigned HeaderBytes = 17;
  localparam int unsigned SymbolDepth = 256;
  localparam int unsigned SymAddrW    = 8;
  // Byte position in the segment saturates here
  localparam int unsigned IndexMax    = 511;
  localparam int unsigned IndexW      = 9;
  localparam int unsigned CodeW       = 17;
  localparam int unsigned AccW        = 16;
  localparam int unsigned LenW        = 5;

  typedef enum logic [1:0] {
    ST_SYMBOL   = 2'd0,
    ST_INVALID  = 2'd1,
    ST_ACCEPTED = 2'd2,
    ST_REJECTED = 2'd3
  } status_e;

  typedef enum logic {
    ACT_TABLE = 1'b0,
    ACT_CODE  = 1'b1
  } action_e;

endpackage

// ----- rtl/core/jpeg_huffman_table_decoder.sv -----
// ----------------------------------------------------------------------------
// JPEG canonical Huffman table decoder
// Loads one table from DHT segment bytes, then decodes code bits against the
// canonical first-code, count and offset tables, one bit per transfer.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid_i/in_ready_o | action_i data_byte_i code_bit_i
//          |                       | table_first_i table_last_i
//  out     | out_valid_o/out_ready_i | symbol_o status_o
//
// One item per cycle; a result appears in the cycle after its input transfer.
// Canonical tables are built one count byte at a time, so no pass follows the
// 16th count. The symbol comes from the store RAM's registered read port.
// Reset leaves no table loaded; the symbol store itself is not cleared.
// Input is taken whenever the result register is empty or being drained.
// ----------------------------------------------------------------------------
module jpeg_huffman_table_decoder
  import jhtd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  input  logic       code_bit_i,
  input  logic       table_first_i,
  input  logic       table_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] symbol_o,
  output logic [1:0] status_o
);

  logic [7:0]        counts_q [NumLengths];
  logic [7:0]        counts_d [NumLengths];
  logic [CodeW-1:0]  first_q  [NumLengths];
  logic [CodeW-1:0]  first_d  [NumLengths];
  logic [IndexW-1:0] offs_q   [NumLengths];
  logic [IndexW-1:0] offs_d   [NumLengths];

  logic [IndexW-1:0] load_index_q, load_index_d;
  logic [IndexW-1:0] expected_q, expected_d;
  logic              ready_q, ready_d;
  logic              bad_q, bad_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [LenW-1:0]   len_q, len_d;
  // running canonical code and symbol count while the counts stream in
  logic [CodeW-1:0]  run_code_q, run_code_d;
  logic [IndexW-1:0] cum_q, cum_d;
  logic [LenW-1:0]   maxlen_q, maxlen_d;
  logic [CodeW-1:0]  last_code_q, last_code_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;

  logic                accept, is_table, is_code;
  logic [IndexW-1:0]   pos, pos_m1, idx_next, store_k;
  logic                pos_zero, pos_cnt;
  logic [LenIdxW-1:0]  cnt_idx;
  logic [CodeW:0]      code_sum, code_limit;
  logic [IndexW:0]     cum_sum;
  logic [IndexW-1:0]   cum_sat;
  logic                store_we;

  logic [AccW-1:0]     acc_n;
  logic [LenW-1:0]     len_n, shamt;
  logic [LenIdxW-1:0]  sel;
  logic [CodeW-1:0]    diff, last_sh;
  logic                ge, hit, dead, no_len;
  logic [IndexW:0]     sym_idx;
  logic [7:0]          ram_rdata;

  assign accept     = in_valid_i && in_ready_o;
  assign is_table   = accept && (action_i == ACT_TABLE);
  assign is_code    = accept && (action_i == ACT_CODE);
  assign in_ready_o = !out_valid_q || out_ready_i;

  // Segment byte position and the incremental table build
  assign pos      = table_first_i ? '0 : load_index_q;
  assign pos_m1   = pos - IndexW'(1);
  assign pos_zero = (pos == '0);
  assign pos_cnt  = !pos_zero && (pos <= IndexW'(NumLengths));
  assign cnt_idx  = pos_m1[LenIdxW-1:0];
  assign idx_next = (pos == IndexW'(IndexMax)) ? pos : pos + IndexW'(1);

  assign code_sum   = {1'b0, run_code_q} + {(CodeW - 7)'(0), data_byte_i};
  assign code_limit = (CodeW + 1)'(2) << cnt_idx;
  assign cum_sum    = {1'b0, cum_q} + {(IndexW - 7)'(0), data_byte_i};
  assign cum_sat    = (cum_sum > (IndexW + 1)'(IndexMax)) ? IndexW'(IndexMax)
                                                          : cum_sum[IndexW-1:0];

  assign store_k  = pos - IndexW'(HeaderBytes);
  assign store_we = is_table && (pos >= IndexW'(HeaderBytes)) &&
                    (store_k < expected_q) && (store_k < IndexW'(SymbolDepth));

  // Code bit path
  assign acc_n   = {acc_q[AccW-2:0], code_bit_i};
  assign len_n   = len_q + LenW'(1);
  assign sel     = len_q[LenIdxW-1:0];
  assign ge      = ({1'b0, acc_n} >= first_q[sel]);
  assign diff    = {1'b0, acc_n} - first_q[sel];
  assign hit     = (counts_q[sel] != '0) && ge && (diff < {(CodeW - 8)'(0), counts_q[sel]});
  // an accepted table keeps every index below the store depth
  assign sym_idx = {1'b0, offs_q[sel]} + {(IndexW - 7)'(0), diff[7:0]};
  assign shamt   = maxlen_q - len_n;
  assign last_sh = last_code_q >> shamt;
  assign no_len  = (maxlen_q == '0) || (len_n > maxlen_q);
  assign dead    = (len_n >= maxlen_q) || ({1'b0, acc_n} > last_sh);

  always_comb begin
    logic    res_valid;
    status_e res_status;
    logic    ok;

    counts_d     = counts_q;
    first_d      = first_q;
    offs_d       = offs_q;
    load_index_d = load_index_q;
    expected_d   = expected_q;
    ready_d      = ready_q;
    bad_d        = bad_q;
    acc_d        = acc_q;
    len_d        = len_q;
    run_code_d   = run_code_q;
    cum_d        = cum_q;
    maxlen_d     = maxlen_q;
    last_code_d  = last_code_q;
    res_valid    = 1'b0;
    res_status   = ST_INVALID;
    ok           = 1'b0;

    if (is_table) begin
      if (pos_zero) begin
        for (int i = 0; i < NumLengths; i++) begin
          counts_d[i] = '0;
          first_d[i]  = '0;
          offs_d[i]   = '0;
        end
        expected_d  = '0;
        ready_d     = 1'b0;
        bad_d       = 1'b0;
        acc_d       = '0;
        len_d       = '0;
        run_code_d  = '0;
        cum_d       = '0;
        maxlen_d    = '0;
        last_code_d = '0;
      end else if (pos_cnt) begin
        counts_d[cnt_idx] = data_byte_i;
        first_d[cnt_idx]  = run_code_q;
        offs_d[cnt_idx]   = cum_q;
        run_code_d        = {code_sum[CodeW-2:0], 1'b0};
        cum_d             = cum_sat;
        // oversubscribed length or too many symbols
        if ((code_sum > code_limit) || (cum_sum > (IndexW + 1)'(SymbolDepth))) begin
          bad_d = 1'b1;
        end
        if (data_byte_i != '0) begin
          maxlen_d    = pos[LenW-1:0];
          last_code_d = code_sum[CodeW-1:0] - CodeW'(1);
        end
        if (pos == IndexW'(NumLengths)) begin
          expected_d = cum_sat;
        end
      end
      load_index_d = idx_next;
      if (table_last_i) begin
        ok = ({1'b0, idx_next} >= (IndexW + 1)'(HeaderBytes)) && !bad_d &&
             ({1'b0, idx_next} >= (IndexW + 1)'(HeaderBytes) + {1'b0, expected_d});
        load_index_d = '0;
        ready_d      = ok;
        acc_d        = '0;
        len_d        = '0;
        res_valid    = 1'b1;
        res_status   = ok ? ST_ACCEPTED : ST_REJECTED;
      end
    end else if (is_code) begin
      acc_d = '0;
      len_d = '0;
      if (!ready_q || no_len) begin
        res_valid  = 1'b1;
        res_status = ST_INVALID;
      end else if (hit) begin
        res_valid  = 1'b1;
        res_status = ST_SYMBOL;
      end else if (dead) begin
        res_valid  = 1'b1;
        res_status = ST_INVALID;
      end else begin
        acc_d = acc_n;
        len_d = len_n;
      end
    end

    if (accept) begin
      out_valid_d = res_valid;
      status_d    = res_valid ? res_status : status_q;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
      status_d    = status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLengths; i++) begin
        counts_q[i] <= '0;
        first_q[i]  <= '0;
        offs_q[i]   <= '0;
      end
      load_index_q <= '0;
      expected_q   <= '0;
      ready_q      <= 1'b0;
      bad_q        <= 1'b0;
      acc_q        <= '0;
      len_q        <= '0;
      run_code_q   <= '0;
      cum_q        <= '0;
      maxlen_q     <= '0;
      last_code_q  <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_INVALID;
    end else begin
      counts_q     <= counts_d;
      first_q      <= first_d;
      offs_q       <= offs_d;
      load_index_q <= load_index_d;
      expected_q   <= expected_d;
      ready_q      <= ready_d;
      bad_q        <= bad_d;
      acc_q        <= acc_d;
      len_q        <= len_d;
      run_code_q   <= run_code_d;
      cum_q        <= cum_d;
      maxlen_q     <= maxlen_d;
      last_code_q  <= last_code_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
    end
  end

  jhtd_ram #(
    .Width (8),
    .Depth (SymbolDepth)
  ) u_symbol_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_k[SymAddrW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (is_code),
    .raddr_i (sym_idx[SymAddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign symbol_o    = (status_q == ST_SYMBOL) ? ram_rdata : '0;

endmodule

// ----- rtl/core/jhtd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data; no reset on the
// array or the read register.
// ----------------------------------------------------------------------------
module jhtd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/jhtd_checker.sv -----
// ----------------------------------------------------------------------------
// JPEG Huffman table decoder port checker
// Watches the decoder's ports for result ordering and handshake slips.
// ----------------------------------------------------------------------------
module jhtd_checker
  import jhtd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       action_i,
  input logic       table_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] symbol_o,
  input logic [1:0] status_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped or changed under stall");

  // the segment end always reports accepted or rejected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (action_i == ACT_TABLE) && table_last_i |=>
      out_valid_o && ((status_o == ST_ACCEPTED) || (status_o == ST_REJECTED)))
    else $error("missing table end report");

  // a middle segment byte makes no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (action_i == ACT_TABLE) && !table_last_i |=> !out_valid_o)
    else $error("spurious result after segment byte");

  // symbol only carries data with a decoded symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_SYMBOL) |-> symbol_o == '0)
    else $error("symbol not zero on non-symbol result");

  // an empty result register never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind jpeg_huffman_table_decoder jhtd_checker u_jhtd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .action_i      (action_i),
  .table_last_i  (table_last_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .symbol_o      (symbol_o),
  .status_o      (status_o)
);

// ----- test/jpeg_huffman_table_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG Huffman table decoder testbench
// Loads DHT tables (well-formed, empty, oversubscribed, truncated, overlong
// and scrambled) and decodes codewords and stray bits against them. Every
// result is checked in order against a canonical-table predictor kept here.
// ----------------------------------------------------------------------------
module jpeg_huffman_table_decoder_tb;
  import jhtd_pkg::*;

  localparam int unsigned ItemTarget   = 1550;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned DirectedRows = 24;
  localparam int unsigned LongSegBytes = 530;

  typedef struct packed {
    logic [7:0] symbol;
    status_e    status;
  } decode_t;

  typedef struct packed {
    action_e    act;
    logic [7:0] data;
    logic       bit_v;
    logic       first;
    logic       last;
    logic       typed;
    decode_t    res;
  } stim_row_t;

  typedef enum int {
    SEG_VALID,
    SEG_EMPTY,
    SEG_OVERSUB,
    SEG_SHORT,
    SEG_LONG,
    SEG_NOISE
  } seg_kind_e;

  localparam decode_t   NoResult  = '{8'h00, ST_SYMBOL};
  localparam stim_row_t CountZero = '{ACT_TABLE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NoResult};

  // Stray bits, short segment, then a table whose only code is one zero bit
  stim_row_t directed_rows [DirectedRows] = '{
    '{ACT_CODE,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, '{8'h00, ST_INVALID}},
    '{ACT_CODE,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, '{8'h00, ST_INVALID}},
    '{ACT_TABLE, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, NoResult},
    '{ACT_TABLE, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, '{8'h00, ST_REJECTED}},
    '{ACT_TABLE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, NoResult},
    '{ACT_TABLE, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, NoResult},
    CountZero, CountZero, CountZero, CountZero, CountZero,
    CountZero, CountZero, CountZero, CountZero, CountZero,
    CountZero, CountZero, CountZero, CountZero, CountZero,
    '{ACT_TABLE, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, '{8'h00, ST_ACCEPTED}},
    '{ACT_CODE,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, '{8'hFF, ST_SYMBOL}},
    '{ACT_CODE,  8'h00, 1'b1, 1'b0, 1'b0, 1'b1, '{8'h00, ST_INVALID}}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  action_e    action;
  logic [7:0] data_byte;
  logic       code_bit;
  logic       table_first;
  logic       table_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] symbol;
  logic [1:0] status;

  // Predictor state
  logic [7:0]         lens_count [NumLengths];
  logic [CodeW-1:0]   first_code [NumLengths];
  logic [IndexW-1:0]  sym_base   [NumLengths];
  logic [7:0]         sym_mem    [SymbolDepth];
  logic [IndexW-1:0]  byte_pos;
  logic [IndexW-1:0]  sym_total;
  bit                 table_live;
  bit                 table_broken;
  logic [AccW-1:0]    code_acc;
  logic [LenW-1:0]    code_len;

  decode_t     decode_queue [$];
  int unsigned items_sent;
  int unsigned cycles;
  int unsigned stall_left;
  int unsigned roll;
  bit          quiet;
  bit          mismatch;

  jpeg_huffman_table_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .data_byte_i   (data_byte),
    .code_bit_i    (code_bit),
    .table_first_i (table_first),
    .table_last_i  (table_last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .symbol_o      (symbol),
    .status_o      (status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned least(input int unsigned a, input int unsigned b,
                                        input int unsigned c);
    int unsigned m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < NumLengths; i++) begin
      lens_count[i] = '0;
      first_code[i] = '0;
      sym_base[i]   = '0;
    end
    sym_total    = '0;
    table_live   = 1'b0;
    table_broken = 1'b0;
    code_acc     = '0;
    code_len     = '0;
  endfunction

  // Canonical first codes and symbol offsets from the 16 counts
  function automatic void assign_codes();
    int unsigned code;
    int unsigned cum;
    code = 0;
    cum  = 0;
    table_broken = 1'b0;
    for (int i = 0; i < NumLengths; i++) begin
      first_code[i] = code[CodeW-1:0];
      sym_base[i]   = (cum > IndexMax) ? 9'(IndexMax) : cum[IndexW-1:0];
      code += lens_count[i];
      cum  += lens_count[i];
      if (code > (32'd1 << (i + 1))) table_broken = 1'b1;
      code = code << 1;
    end
    sym_total = (cum > IndexMax) ? 9'(IndexMax) : cum[IndexW-1:0];
    if (cum > SymbolDepth) table_broken = 1'b1;
  endfunction

  task automatic decode_item(input action_e act, input logic [7:0] b, input logic cb,
                             input logic tf, input logic tl, output bit got,
                             output decode_t res);
    int unsigned pos;
    int unsigned k;
    int unsigned nlen;
    int unsigned maxlen;
    int unsigned cnt;
    int unsigned fc;
    int unsigned lastc;
    int unsigned idx;
    logic [AccW-1:0] acc_n;
    bit ok;
    got = 1'b0;
    res = NoResult;
    if (act == ACT_TABLE) begin
      if (tf) byte_pos = '0;
      pos = byte_pos;
      if (pos == 0) begin
        wipe_table();
      end else if (pos <= NumLengths) begin
        lens_count[pos - 1] = b;
        if (pos == NumLengths) assign_codes();
      end else begin
        k = pos - HeaderBytes;
        if (k < sym_total && k < SymbolDepth) sym_mem[k[7:0]] = b;
      end
      if (byte_pos < IndexMax) byte_pos = byte_pos + 9'd1;
      if (tl) begin
        ok = byte_pos >= HeaderBytes && !table_broken &&
             byte_pos >= HeaderBytes + sym_total;
        byte_pos   = '0;
        table_live = ok;
        code_acc   = '0;
        code_len   = '0;
        got        = 1'b1;
        res.status = ok ? ST_ACCEPTED : ST_REJECTED;
      end
    end else begin
      got        = 1'b1;
      res.status = ST_INVALID;
      maxlen     = 0;
      for (int i = 0; i < NumLengths; i++)
        if (lens_count[i] != 0) maxlen = i + 1;
      acc_n = {code_acc[AccW-2:0], cb};
      nlen  = code_len + 1;
      if (table_live && maxlen != 0 && nlen <= maxlen) begin
        cnt   = lens_count[nlen - 1];
        fc    = first_code[nlen - 1];
        lastc = first_code[maxlen - 1] + lens_count[maxlen - 1] - 1;
        if (cnt != 0 && acc_n >= fc && acc_n - fc < cnt) begin
          idx = sym_base[nlen - 1] + (acc_n - fc);
          res = '{(idx < SymbolDepth) ? sym_mem[idx[7:0]] : 8'h00, ST_SYMBOL};
        end else if (nlen < maxlen && acc_n <= (lastc >> (maxlen - nlen))) begin
          // prefix can still grow into a code: hold the bits
          got = 1'b0;
        end
      end
      if (got) begin
        code_acc = '0;
        code_len = '0;
      end else begin
        code_acc = acc_n;
        code_len = nlen[LenW-1:0];
      end
    end
  endtask

  task automatic push_item(input action_e act, input logic [7:0] b, input logic cb,
                           input logic tf, input logic tl, input bit counted,
                           input logic typed, input decode_t typed_res);
    int unsigned gap;
    bit got;
    decode_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    action      = act;
    data_byte   = b;
    code_bit    = cb;
    table_first = tf;
    table_last  = tl;
    do @(posedge clk); while (!in_ready);
    decode_item(act, b, cb, tf, tl, got, res);
    if (got) decode_queue.push_back(typed ? typed_res : res);
    if (counted) items_sent++;
  endtask

  task automatic random_bit();
    push_item(ACT_CODE, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              1'b1, 1'b0, NoResult);
  endtask

  // Send the canonical code of symbol number idx, most significant bit first
  task automatic send_codeword(input int unsigned idx);
    int unsigned len;
    int unsigned code;
    len  = 0;
    code = 0;
    for (int i = 0; i < NumLengths; i++)
      if (lens_count[i] != 0 && idx >= sym_base[i] && idx < sym_base[i] + lens_count[i]) begin
        len  = i + 1;
        code = first_code[i] + (idx - sym_base[i]);
      end
    for (int i = int'(len) - 1; i >= 0; i--)
      push_item(ACT_CODE, 8'($urandom), code[i], 1'($urandom), 1'($urandom),
                1'b1, 1'b0, NoResult);
  endtask

  task automatic run_segment(input seg_kind_e kind);
    logic [7:0] seg [$];
    logic [7:0] counts [NumLengths];
    int unsigned budget;
    int unsigned maxlen;
    int unsigned free;
    int unsigned total;
    int unsigned cnt;
    int unsigned lim;
    int unsigned keep;
    int unsigned len_sel;
    bit big;
    if (kind == SEG_NOISE) begin
      repeat ($urandom_range(8, 24))
        push_item(action_e'($urandom_range(0, 1)), 8'($urandom), 1'($urandom),
                  $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                  1'b1, 1'b0, NoResult);
      return;
    end
    total = 0;
    for (int i = 0; i < NumLengths; i++) counts[i] = '0;
    if (kind == SEG_OVERSUB) begin
      if ($urandom_range(0, 3) == 0) begin
        // too many symbols for the store
        for (int i = 8; i < NumLengths; i++) counts[i] = 8'hFF;
      end else begin
        for (int i = 0; i < 6; i++) counts[i] = 8'($urandom_range(0, 2));
        len_sel = $urandom_range(1, 4);
        counts[len_sel - 1] = 8'((1 << len_sel) + $urandom_range(1, 3));
      end
      for (int i = 0; i < NumLengths; i++) total += counts[i];
      total = least(total, 20, 20);
    end else if (kind != SEG_EMPTY) begin
      big    = ($urandom_range(0, 24) == 0);
      budget = big ? SymbolDepth : $urandom_range(1, 24);
      if (big) maxlen = NumLengths;
      else if ($urandom_range(0, 3) == 0) maxlen = $urandom_range(9, 16);
      else maxlen = $urandom_range(1, 8);
      free = 1;
      for (int l = 1; l <= NumLengths; l++) begin
        // an under-count of free codes is safe
        if (free < 65536) free = free * 2;
        cnt = 0;
        if (l < maxlen) begin
          lim = least(free - 1, budget - total - 1, 255);
          if (lim > 0 && $urandom_range(0, 1) == 1) cnt = $urandom_range(0, lim);
        end else if (l == maxlen) begin
          lim = least(free, budget - total, 255);
          cnt = ($urandom_range(0, 1) == 1) ? lim : $urandom_range(1, lim);
        end
        free  -= cnt;
        total += cnt;
        counts[l - 1] = cnt[7:0];
      end
    end
    seg.push_back(8'($urandom));
    for (int i = 0; i < NumLengths; i++) seg.push_back(counts[i]);
    repeat (total) seg.push_back(8'($urandom));
    if (kind == SEG_LONG) begin
      while (seg.size() < LongSegBytes) seg.push_back(8'($urandom));
    end else if (kind == SEG_SHORT) begin
      keep = $urandom_range(1, seg.size() - 1);
      while (seg.size() > keep) void'(seg.pop_back());
    end else if (kind == SEG_VALID && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) seg.push_back(8'($urandom));
    end
    foreach (seg[i])
      push_item(ACT_TABLE, seg[i], 1'($urandom),
                (i == 0) ? ($urandom_range(0, 7) != 0) : 1'b0,
                i == seg.size() - 1, 1'b1, 1'b0, NoResult);
    // decode against whatever the segment left behind
    repeat ($urandom_range(4, 30)) begin
      if (table_live && sym_total != 0 && $urandom_range(0, 3) != 0)
        send_codeword($urandom_range(0, sym_total - 1));
      else
        repeat ($urandom_range(1, 3)) random_bit();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      roll = $urandom_range(0, 99);
      if (!quiet && roll < 20) stall_left = $urandom_range(1, 3);
      else if (!quiet && roll < 23) stall_left = $urandom_range(8, 30);
    end
  end

  always @(posedge clk) begin
    decode_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decode_queue.size() == 0) begin
        $error("unexpected transfer: symbol %0d status %0d", symbol, status);
        mismatch = 1'b1;
      end else begin
        want = decode_queue.pop_front();
        if (symbol !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, symbol);
          mismatch = 1'b1;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    seg_kind_e kind;
    int unsigned r;
    in_valid    = 1'b0;
    action      = ACT_TABLE;
    data_byte   = 8'h00;
    code_bit    = 1'b0;
    table_first = 1'b0;
    table_last  = 1'b0;
    out_ready   = 1'b0;
    rst_n       = 1'b0;
    quiet       = 1'b0;
    mismatch    = 1'b0;
    items_sent  = 0;
    cycles      = 0;
    stall_left  = 0;
    byte_pos    = '0;
    wipe_table();
    for (int i = 0; i < SymbolDepth; i++) sym_mem[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      push_item(directed_rows[i].act, directed_rows[i].data, directed_rows[i].bit_v,
                directed_rows[i].first, directed_rows[i].last, 1'b1,
                directed_rows[i].typed, directed_rows[i].res);

    // one of each segment kind first, then mostly well-formed tables
    for (int s = 0; items_sent < ItemTarget; s++) begin
      quiet = ($urandom_range(0, 5) == 0);
      if (s < 6) begin
        kind = seg_kind_e'(s);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) kind = SEG_VALID;
        else if (r < 76) kind = SEG_EMPTY;
        else if (r < 84) kind = SEG_OVERSUB;
        else if (r < 91) kind = SEG_SHORT;
        else kind = SEG_NOISE;
      end
      run_segment(kind);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (decode_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!mismatch) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
